// ----- rtl/wpsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wpsp_pkg
// Types, constants and helpers shared by the WAVE PCM16 stream parser.
// ----------------------------------------------------------------------------
package wpsp_pkg;

  localparam int unsigned OUT_DEPTH = 8;

  localparam logic [3:0]  HDR_BYTES     = 4'd12;
  localparam logic [31:0] TAG_FMT       = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA      = 32'h6174_6164;
  localparam logic [15:0] FMT_PCM       = 16'h0001;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
  localparam logic [31:0] FMT_MIN_EXT   = 32'd26;
  localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
  localparam logic [15:0] PCM_BITS      = 16'd16;
  localparam logic [3:0]  CHUNK_MAX     = 4'd15;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_RIFF = 2'd1,
    ST_BAD_FMT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CK_HEADER = 2'd0,
    CK_FMT    = 2'd1,
    CK_DATA   = 2'd2,
    CK_OTHER  = 2'd3
  } chunk_kind_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic               item_kind;
    logic signed [15:0] pcm_sample;
    logic [3:0]         chunk_number;
    logic [1:0]         status_code;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [15:0]        audio_format;
    logic [15:0]        sample_bits;
    logic               end_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  function automatic logic [7:0] riff_wave_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h52;
      4'd1:    v = 8'h49;
      4'd2:    v = 8'h46;
      4'd3:    v = 8'h46;
      4'd8:    v = 8'h57;
      4'd9:    v = 8'h41;
      4'd10:   v = 8'h56;
      4'd11:   v = 8'h45;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/wpsp_parser.sv -----
// ----------------------------------------------------------------------------
// wpsp_parser
// Input register and per-byte parse logic: header check, chunk walk, fmt
// capture and sample assembly, producing up to two result items per byte.
// ----------------------------------------------------------------------------
module wpsp_parser import wpsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     busy_o,
  output push_t    push_o
);

  typedef struct packed {
    logic [15:0] format;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [15:0] sub;
  } fmt_t;

  logic        s0_valid_q;
  in_item_t    s0_item_q;

  logic [3:0]  pos_q, pos_d;
  logic        hok_q, hok_d;
  logic [63:0] shift_q, shift_d;
  logic [31:0] left_q, left_d;
  chunk_kind_e kind_q, kind_d;
  logic        pad_q, pad_d;
  fmt_t        pend_q, pend_d;
  fmt_t        comm_q, comm_d;
  logic [7:0]  low_q, low_d;
  logic        phase_q, phase_d;
  logic [3:0]  dcount_q, dcount_d;
  logic [3:0]  cur_q, cur_d;
  logic [3:0]  chosen_q, chosen_d;
  logic        seen_q, seen_d;

  logic [7:0]  b;
  logic        checked;
  logic        match;
  logic        do_finish;
  logic [31:0] size;
  logic [31:0] off;
  logic        bad;
  out_item_t   sample_r;
  out_item_t   status_r;

  assign busy_o = s0_valid_q;
  assign b      = s0_item_q.file_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s0_item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hok_q    <= 1'b0;
      shift_q  <= '0;
      left_q   <= '0;
      kind_q   <= CK_HEADER;
      pad_q    <= 1'b0;
      pend_q   <= '0;
      comm_q   <= '0;
      low_q    <= '0;
      phase_q  <= 1'b0;
      dcount_q <= '0;
      cur_q    <= '0;
      chosen_q <= '0;
      seen_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      hok_q    <= hok_d;
      shift_q  <= shift_d;
      left_q   <= left_d;
      kind_q   <= kind_d;
      pad_q    <= pad_d;
      pend_q   <= pend_d;
      comm_q   <= comm_d;
      low_q    <= low_d;
      phase_q  <= phase_d;
      dcount_q <= dcount_d;
      cur_q    <= cur_d;
      chosen_q <= chosen_d;
      seen_q   <= seen_d;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    hok_d     = hok_q;
    shift_d   = shift_q;
    left_d    = left_q;
    kind_d    = kind_q;
    pad_d     = pad_q;
    pend_d    = pend_q;
    comm_d    = comm_q;
    low_d     = low_q;
    phase_d   = phase_q;
    dcount_d  = dcount_q;
    cur_d     = cur_q;
    chosen_d  = chosen_q;
    seen_d    = seen_q;
    do_finish = 1'b0;
    checked   = (pos_q < 4'd4) || (pos_q >= 4'd8);
    match     = !checked || (b == riff_wave_byte(pos_q));
    off       = shift_q[63:32] - left_q;
    sample_r  = '0;
    status_r  = '0;
    bad       = 1'b0;
    push_o    = '0;

    if (s0_valid_q) begin
      if (pos_q < HDR_BYTES) begin
        hok_d = (pos_q == 4'd0) ? match : (hok_q & match);
      end else if (kind_q == CK_HEADER) begin
        if (pad_q) begin
          pad_d = 1'b0;
        end else begin
          shift_d = {b, shift_q[63:8]};
          left_d  = left_q + 32'd1;
          if (left_q[2:0] == 3'd7) begin
            case (shift_d[31:0])
              TAG_FMT: begin
                kind_d = CK_FMT;
                pend_d = '0;
              end
              TAG_DATA: begin
                kind_d  = CK_DATA;
                cur_d   = dcount_q;
                phase_d = 1'b0;
                if (dcount_q != CHUNK_MAX) begin
                  dcount_d = dcount_q + 4'd1;
                end
              end
              default: begin
                kind_d = CK_OTHER;
              end
            endcase
            left_d    = shift_d[63:32];
            do_finish = (shift_d[63:32] == '0);
          end
        end
      end else begin
        case (kind_q)
          CK_FMT: begin
            if (off < 32'd2) begin
              if (off[0]) pend_d.format[15:8] = b;
              else pend_d.format[7:0] = b;
            end else if (off < 32'd4) begin
              if (off[0]) pend_d.channels[15:8] = b;
              else pend_d.channels[7:0] = b;
            end else if (off < 32'd8) begin
              case (off[1:0])
                2'd0:    pend_d.rate[7:0]   = b;
                2'd1:    pend_d.rate[15:8]  = b;
                2'd2:    pend_d.rate[23:16] = b;
                default: pend_d.rate[31:24] = b;
              endcase
            end else if (off == 32'd14) begin
              pend_d.bits[7:0] = b;
            end else if (off == 32'd15) begin
              pend_d.bits[15:8] = b;
            end else if (off == 32'd24) begin
              pend_d.sub[7:0] = b;
            end else if (off == 32'd25) begin
              pend_d.sub[15:8] = b;
            end
          end
          CK_DATA: begin
            if (!phase_q) begin
              low_d   = b;
              phase_d = 1'b1;
            end else begin
              phase_d               = 1'b0;
              sample_r.item_kind    = KIND_SAMPLE;
              sample_r.pcm_sample   = $signed({b, low_q});
              sample_r.chunk_number = cur_q;
              push_o.cnt            = 2'd1;
              push_o.first          = sample_r;
            end
          end
          default: begin
          end
        endcase
        left_d    = left_q - 32'd1;
        do_finish = (left_q == 32'd1);
      end

      size = shift_d[63:32];
      if (do_finish) begin
        if ((kind_d == CK_FMT) && (size >= FMT_MIN_SIZE)) begin
          comm_d = pend_d;
          if ((pend_d.format == FMT_EXTENSIBLE) && (size >= FMT_MIN_EXT)) begin
            comm_d.format = pend_d.sub;
          end
        end else if (kind_d == CK_DATA) begin
          chosen_d = cur_d;
          seen_d   = 1'b1;
        end
        pad_d  = size[0];
        kind_d = CK_HEADER;
        left_d = '0;
      end

      if (pos_q != HDR_BYTES) begin
        pos_d = pos_q + 4'd1;
      end

      if (s0_item_q.final_byte) begin
        status_r.item_kind    = KIND_STATUS;
        status_r.end_of_run   = 1'b1;
        status_r.chunk_number = seen_d ? chosen_d : 4'd0;
        if ((pos_d < HDR_BYTES) || !hok_d) begin
          status_r.status_code = ST_NOT_RIFF;
        end else begin
          bad = (comm_d.format != FMT_PCM) || (comm_d.bits != PCM_BITS) ||
                (comm_d.channels == '0) || (comm_d.rate == '0) ||
                comm_d.rate[31] || !seen_d;
          status_r.status_code   = bad ? ST_BAD_FMT : ST_OK;
          status_r.channel_count = comm_d.channels;
          status_r.sample_rate   = comm_d.rate;
          status_r.audio_format  = comm_d.format;
          status_r.sample_bits   = comm_d.bits;
        end
        if (push_o.cnt == 2'd1) begin
          push_o.cnt    = 2'd2;
          push_o.second = status_r;
        end else begin
          push_o.cnt   = 2'd1;
          push_o.first = status_r;
        end
        pos_d    = '0;
        hok_d    = 1'b0;
        shift_d  = '0;
        left_d   = '0;
        kind_d   = CK_HEADER;
        pad_d    = 1'b0;
        pend_d   = '0;
        comm_d   = '0;
        low_d    = '0;
        phase_d  = 1'b0;
        dcount_d = '0;
        cur_d    = '0;
        chosen_d = '0;
        seen_d   = 1'b0;
      end
    end else begin
      size = shift_q[63:32];
    end
  end

endmodule

// ----- rtl/wpsp_outq.sv -----
// ----------------------------------------------------------------------------
// wpsp_outq
// Result queue that takes up to two result items per cycle and hands them
// out one at a time on a valid/ready channel.
// ----------------------------------------------------------------------------
module wpsp_outq import wpsp_pkg::*; #(
  parameter int unsigned Depth = OUT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  push_t                      push_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output out_item_t                  out_item_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  out_item_t       mem_q [Depth];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic [PW-1:0]   wnext;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
  endfunction

  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rptr_q];
  assign count_o     = count_q;
  assign pop         = out_valid_o && out_ready_i;
  assign wnext       = ptr_inc(wptr_q);

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    if (push_i.cnt == 2'd1) begin
      wptr_d = wnext;
    end else if (push_i.cnt == 2'd2) begin
      wptr_d = ptr_inc(wnext);
    end
    if (pop) begin
      rptr_d = ptr_inc(rptr_q);
    end
    count_d = count_q + CW'(push_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wnext] <= push_i.second;
    end
  end

endmodule

// ----- rtl/wave_pcm16_stream_parser_top.sv -----
// ----------------------------------------------------------------------------
// wave_pcm16_stream_parser_top
// Byte-wide RIFF/WAVE 16-bit PCM parser emitting samples and a final status.
// ----------------------------------------------------------------------------
// An accepted byte is held in the parser's input register, and its result items are written into the result queue.
// Throughput: one byte per cycle while the result queue has room; a byte yields at most two result items.
// The result queue depth sets how long input keeps flowing while the output
// side stalls, since each byte in flight reserves two queue entries.
// Reset clears the parser state and empties the result queue.
module wave_pcm16_stream_parser_top import wpsp_pkg::*; #(
  parameter int unsigned OutDepth = OUT_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned CW = $clog2(OutDepth + 1);

  logic          busy;
  push_t         push;
  logic [CW-1:0] count;
  logic [CW+1:0] need;

  assign need       = {2'b00, count} + (busy ? (CW+2)'(2) : '0) + (CW+2)'(2);
  assign in_ready_o = (need <= (CW+2)'(OutDepth));

  wpsp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_valid_i && in_ready_o),
    .item_i   (in_item_i),
    .busy_o   (busy),
    .push_o   (push)
  );

  wpsp_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .count_o     (count)
  );

endmodule

// ----- rtl/wpsp_checker.sv -----
// ----------------------------------------------------------------------------
// wpsp_checker
// Port-level assertions for the WAVE PCM16 stream parser, bound to the top.
// ----------------------------------------------------------------------------
module wpsp_checker import wpsp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Result item changed or dropped while stalled.");

  a_kind_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.item_kind == out_item_o.end_of_run))
    else $error("End of run flag does not match the item kind.");

  a_sample_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.item_kind == KIND_SAMPLE) |->
      (out_item_o.status_code == ST_OK) && (out_item_o.sample_rate == '0))
    else $error("Sample item carries status fields.");

  a_not_riff_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status_code == ST_NOT_RIFF) |->
      (out_item_o.pcm_sample == '0) && (out_item_o.channel_count == '0) &&
      (out_item_o.sample_rate == '0) && (out_item_o.audio_format == '0) &&
      (out_item_o.sample_bits == '0))
    else $error("Rejected file reports format fields.");

  a_first_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !$past(in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("Result item offered without an accepted item.");

endmodule

bind wave_pcm16_stream_parser_top wpsp_checker u_wpsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
